[src/sam_pkg.sv]
// shared types, constants and opcodes for the suffix automaton matcher
// no dependencies
`default_nettype none
package sam_pkg;
    localparam int MaxText   = 1024;
    localparam int Alphabet  = 26;
    localparam int MaxQuery  = 65536;
    localparam int States    = 2 * MaxText;
    localparam int StW       = $clog2(States);        // state index width
    localparam int LnkW      = StW + 1;               // link width, msb marks none
    localparam int LenW      = 11;
    localparam int PosW      = 16;
    localparam int SymW      = 5;
    localparam int AlphW     = $clog2(Alphabet);
    localparam int TAddrW    = StW + AlphW;           // transition memory address width

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_RESP,
        S_CLR,                                  // clearing pass over transitions
        S_CLR_ROOT,                             // clear: root transitions zeroed
        S_A_CHK, S_A_NEWW, S_A_NEWR,            // append: check, alloc new state
        S_A_W1R, S_A_W1T, S_A_W1L,              // first link walk
        S_A_QD, S_A_QDR, S_A_CLN, S_A_CPR, S_A_CPW,
        S_A_W2R, S_A_W2T, S_A_W2L,
        S_Q_T, S_Q_TR, S_Q_WL, S_Q_WT, S_Q_WTR, S_Q_DEP, S_Q_DEPR, S_Q_UPD
    } t_state;

    typedef struct packed {
        t_state st;
    } t_cmd;

    typedef struct packed {
        logic        clr_done;
        logic        cpy_done;
        logic        full;
        logic        sym_bad;
        logic        tr_zero;      // read transition is zero
        logic        tr_eq_q;      // read transition equals q
        logic        link_none;    // walk pointer or its read link is none
        logic        solid;        // depth[q] == depth[c]+1
        logic        hit_direct;   // query transition nonzero
    } t_stat;
endpackage
`default_nettype wire

[src/suffix_automaton_lcs_top.sv]
// top level of the suffix automaton longest common substring block
// depends on sam_pkg, sam_ctrl, sam_dp
`default_nettype none
// usage
//   command channel: drive i_opcode and i_symbol with start; a transfer
//   happens at an edge with start high and busy low
//   opcode clear empties the automaton, append adds one text symbol,
//   query matches one symbol and updates match and best figures
//   result: one per command, on the o_ ports for one cycle with o_done high
//   steps of each command:
//   unused opcode: response only; clear: root's 26 transitions zeroed, one per cycle
//   append: response only when rejected or ignored, else the new state's row is
//   zeroed, then a suffix link walk stops at none or at an existing transition;
//   a clone copies 26 transitions, then a repair walk redirects transitions
//   and stops at a different transition
//   query: a symbol outside the alphabet or a direct hit goes straight to the
//   update; a mismatch tries one state per step along the suffix links and
//   reads the depth when a match is found
//   the transition memory takes one read and one write per cycle
//   reset: a clearing pass zeroes the whole transition memory,
//   busy stays high meanwhile
//   the receiver cannot stall; results must be taken when o_done is high
module suffix_automaton_lcs_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_opcode,
    input  wire  [4:0]  i_symbol,
    output logic        o_done,
    output logic        o_status,
    output logic [10:0] o_match_length,
    output logic [10:0] o_best_length,
    output logic [15:0] o_best_start
);
    sam_pkg::t_cmd  cmd;
    sam_pkg::t_stat stat;
    logic go;

    assign go = start & ~busy;

    sam_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_op(i_opcode),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy), .o_done(o_done)
    );

    sam_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_op(i_opcode),
        .i_sym(i_symbol), .i_cmd(cmd), .o_stat(stat), .o_status(o_status),
        .o_mlen(o_match_length), .o_blen(o_best_length), .o_bstart(o_best_start)
    );
endmodule
`default_nettype wire

[src/sam_ctrl.sv]
// controller state machine for the suffix automaton matcher
// depends on sam_pkg
`default_nettype none
module sam_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_go,
    input  wire [1:0]             i_op,
    input  wire sam_pkg::t_stat   i_stat,
    output sam_pkg::t_cmd         o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);
    sam_pkg::t_state r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= sam_pkg::S_CLR;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            sam_pkg::S_IDLE: begin
                if (i_go) begin
                    case (i_op)
                        sam_pkg::OP_CLEAR:  n_st = sam_pkg::S_CLR_ROOT;
                        sam_pkg::OP_APPEND: n_st = sam_pkg::S_A_CHK;
                        sam_pkg::OP_QUERY:  n_st = sam_pkg::S_Q_T;
                        default:            n_st = sam_pkg::S_RESP;
                    endcase
                end
            end
            sam_pkg::S_RESP:   n_st = sam_pkg::S_IDLE;
            sam_pkg::S_CLR:    if (i_stat.clr_done) n_st = sam_pkg::S_IDLE;
            sam_pkg::S_CLR_ROOT: if (i_stat.clr_done) n_st = sam_pkg::S_RESP;
            sam_pkg::S_A_CHK:
                if (i_stat.sym_bad || i_stat.full) n_st = sam_pkg::S_RESP;
                else n_st = sam_pkg::S_A_NEWW;
            sam_pkg::S_A_NEWW: if (i_stat.clr_done) n_st = sam_pkg::S_A_W1R;
            sam_pkg::S_A_NEWR: n_st = sam_pkg::S_A_W1R;
            sam_pkg::S_A_W1R:  n_st = sam_pkg::S_A_W1T;
            sam_pkg::S_A_W1T:  n_st = i_stat.tr_zero ? sam_pkg::S_A_W1L : sam_pkg::S_A_QD;
            sam_pkg::S_A_W1L:  n_st = i_stat.link_none ? sam_pkg::S_RESP : sam_pkg::S_A_W1R;
            sam_pkg::S_A_QD:   n_st = sam_pkg::S_A_QDR;
            sam_pkg::S_A_QDR:  n_st = i_stat.solid ? sam_pkg::S_RESP : sam_pkg::S_A_CLN;
            sam_pkg::S_A_CLN:  n_st = sam_pkg::S_A_CPR;
            sam_pkg::S_A_CPR:  n_st = sam_pkg::S_A_CPW;
            sam_pkg::S_A_CPW:  n_st = i_stat.cpy_done ? sam_pkg::S_A_W2R : sam_pkg::S_A_CPR;
            sam_pkg::S_A_W2R:  n_st = sam_pkg::S_A_W2T;
            sam_pkg::S_A_W2T:  n_st = i_stat.tr_eq_q ? sam_pkg::S_A_W2L : sam_pkg::S_RESP;
            sam_pkg::S_A_W2L:  n_st = i_stat.link_none ? sam_pkg::S_RESP : sam_pkg::S_A_W2R;
            sam_pkg::S_Q_T:
                n_st = i_stat.sym_bad ? sam_pkg::S_Q_UPD : sam_pkg::S_Q_TR;
            sam_pkg::S_Q_TR:
                n_st = i_stat.hit_direct ? sam_pkg::S_Q_UPD : sam_pkg::S_Q_WL;
            sam_pkg::S_Q_WL:   n_st = i_stat.link_none ? sam_pkg::S_Q_UPD : sam_pkg::S_Q_WT;
            sam_pkg::S_Q_WT:   n_st = sam_pkg::S_Q_WTR;
            sam_pkg::S_Q_WTR:  n_st = i_stat.tr_zero ? sam_pkg::S_Q_WL : sam_pkg::S_Q_DEP;
            sam_pkg::S_Q_DEP:  n_st = sam_pkg::S_Q_DEPR;
            sam_pkg::S_Q_DEPR: n_st = sam_pkg::S_Q_UPD;
            sam_pkg::S_Q_UPD:  n_st = sam_pkg::S_RESP;
            default:           n_st = sam_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.st = r_st;
        o_busy   = (r_st != sam_pkg::S_IDLE);
        o_done   = (r_st == sam_pkg::S_RESP);
    end
endmodule
`default_nettype wire

[src/sam_dp.sv]
// datapath of the suffix automaton matcher: transition, link and depth memories
// depends on sam_pkg
`default_nettype none
module sam_dp (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_go,
    input  wire [1:0]                 i_op,
    input  wire [sam_pkg::SymW-1:0]   i_sym,
    input  wire sam_pkg::t_cmd        i_cmd,
    output sam_pkg::t_stat            o_stat,
    output logic                      o_status,
    output logic [sam_pkg::LenW-1:0]  o_mlen,
    output logic [sam_pkg::LenW-1:0]  o_blen,
    output logic [sam_pkg::PosW-1:0]  o_bstart
);
    localparam int StW = sam_pkg::StW;
    localparam int LnkW = sam_pkg::LnkW;
    localparam int AW = sam_pkg::AlphW;
    localparam int TW = sam_pkg::TAddrW;
    localparam logic [LnkW-1:0] NoLink = LnkW'(sam_pkg::States);

    // transitions addressed {state, symbol}; zero means none
    logic [StW-1:0]  mem_tr [0:(1<<TW)-1];
    logic [LnkW-1:0] mem_lk [0:sam_pkg::States-1];
    logic [sam_pkg::LenW-1:0] mem_dp [0:sam_pkg::States-1];

    logic [AW-1:0] r_sym;
    logic          r_bad;
    logic [StW:0]  r_cnt;        // state count
    logic [StW-1:0] r_last, r_mst, r_p, r_q, r_r;
    logic [LnkW-1:0] r_c;
    logic [sam_pkg::LenW-1:0] r_len, r_best, r_dlast, r_dc;
    logic [sam_pkg::PosW-1:0] r_bst, r_pos;
    logic          r_status;
    logic [AW-1:0] r_k;          // sweep symbol counter
    logic [TW-1:0] r_clra;
    logic [StW-1:0] r_trd;
    logic [LnkW-1:0] r_lkd;
    logic [sam_pkg::LenW-1:0] r_dpd;

    // memory port control
    logic          tr_we;
    logic [TW-1:0] tr_wa, tr_ra;
    logic [StW-1:0] tr_wd;
    logic          lk_we;
    logic [StW-1:0] lk_wa, lk_ra, dp_ra;
    logic [LnkW-1:0] lk_wd;
    logic          dp_we;
    logic [StW-1:0] dp_wa;
    logic [sam_pkg::LenW-1:0] dp_wd;
    logic [StW-1:0] cst;
    logic [sam_pkg::LenW-1:0] nlen;

    assign cst = r_c[StW-1:0];
    assign nlen = r_len + 1'b1;

    always_comb begin
        tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = '0;
        lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = cst;
        dp_we = 1'b0; dp_wa = '0; dp_wd = '0; dp_ra = r_last;
        case (i_cmd.st)
            sam_pkg::S_CLR: begin
                tr_we = 1'b1; tr_wa = r_clra;
            end
            sam_pkg::S_CLR_ROOT: begin
                tr_we = 1'b1; tr_wa = {{StW{1'b0}}, r_k};
            end
            sam_pkg::S_A_NEWW: begin
                tr_we = 1'b1; tr_wa = {r_p, r_k};
            end
            sam_pkg::S_A_W1R, sam_pkg::S_A_W2R: tr_ra = {cst, r_sym};
            sam_pkg::S_A_W1T: begin
                if (r_trd == '0) begin
                    tr_we = 1'b1; tr_wa = {cst, r_sym}; tr_wd = r_p;
                end
            end
            sam_pkg::S_A_QD: dp_ra = r_q;
            sam_pkg::S_A_CPR: tr_ra = {r_q, r_k};
            sam_pkg::S_A_CPW: begin
                tr_we = 1'b1; tr_wa = {r_r, r_k}; tr_wd = r_trd;
            end
            sam_pkg::S_A_W2T: begin
                if (r_trd == r_q) begin
                    tr_we = 1'b1; tr_wa = {cst, r_sym}; tr_wd = r_r;
                end
            end
            sam_pkg::S_Q_T: tr_ra = {r_mst, r_sym};
            sam_pkg::S_Q_WT: tr_ra = {cst, r_sym};
            sam_pkg::S_Q_DEP: dp_ra = cst;
            default: ;
        endcase
        // link and depth writes, one per state
        case (i_cmd.st)
            sam_pkg::S_CLR: begin
                lk_we = 1'b1; lk_wa = '0; lk_wd = NoLink;
                dp_we = 1'b1; dp_wa = '0; dp_wd = '0;
            end
            sam_pkg::S_A_NEWW: begin
                dp_we = (r_k == '0); dp_wa = r_p; dp_wd = r_dlast + 1'b1;
            end
            sam_pkg::S_A_W1L: begin
                if (r_lkd == NoLink) begin
                    lk_we = 1'b1; lk_wa = r_p; lk_wd = '0;
                end
            end
            sam_pkg::S_A_QDR: begin
                lk_we = 1'b1; lk_wa = r_p; lk_wd = LnkW'(r_q);
            end
            sam_pkg::S_A_CLN: begin
                lk_we = 1'b1; lk_wa = r_r; dp_we = 1'b1; dp_wa = r_r;
                dp_wd = r_dc + 1'b1; lk_ra = r_q;
            end
            sam_pkg::S_A_CPR: begin
                lk_ra = r_q;
                lk_we = (r_k == '0); lk_wa = r_r; lk_wd = r_lkd;
            end
            sam_pkg::S_A_CPW: begin
                lk_we = 1'b1; lk_wa = r_q; lk_wd = LnkW'(r_r);
            end
            sam_pkg::S_A_W2T: begin
                lk_we = 1'b1; lk_wa = r_p; lk_wd = LnkW'(r_r);
            end
            default: ;
        endcase
        // depth of the walk pointer is read alongside its transition
        if (i_cmd.st == sam_pkg::S_A_W1R || i_cmd.st == sam_pkg::S_A_W2R
            || i_cmd.st == sam_pkg::S_A_W1T || i_cmd.st == sam_pkg::S_A_W2T
            || i_cmd.st == sam_pkg::S_Q_TR || i_cmd.st == sam_pkg::S_Q_WTR)
            dp_ra = cst;
    end

    always_ff @(posedge i_clk) begin
        if (tr_we) mem_tr[tr_wa] <= tr_wd;
        r_trd <= mem_tr[tr_ra];
        if (lk_we) mem_lk[lk_wa] <= lk_wd;
        r_lkd <= mem_lk[lk_ra];
        if (dp_we) mem_dp[dp_wa] <= dp_wd;
        r_dpd <= mem_dp[dp_ra];
    end

    logic last_k;
    assign last_k = (r_k == AW'(sam_pkg::Alphabet - 1));

    always_comb begin
        o_stat.clr_done   = (i_cmd.st == sam_pkg::S_CLR) ? (r_clra == '1) : last_k;
        o_stat.cpy_done   = last_k;
        o_stat.full       = (r_dlast >= sam_pkg::LenW'(sam_pkg::MaxText))
                            || (r_cnt + 2'd2 > (StW+1)'(sam_pkg::States));
        o_stat.sym_bad    = r_bad;
        o_stat.tr_zero    = (r_trd == '0);
        o_stat.tr_eq_q    = (r_trd == r_q);
        o_stat.link_none  = (i_cmd.st == sam_pkg::S_Q_WL) ? (r_c == NoLink)
                            : (r_lkd == NoLink);
        o_stat.solid      = (r_dpd == r_dc + 1'b1);
        o_stat.hit_direct = (r_trd != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clra <= '0; r_k <= '0; r_cnt <= (StW+1)'(1); r_last <= '0; r_mst <= '0;
            r_len <= '0; r_best <= '0; r_bst <= '0; r_pos <= '0; r_status <= 1'b0;
            r_dlast <= '0;
        end else begin
            case (i_cmd.st)
                sam_pkg::S_IDLE: begin
                    r_sym <= i_sym[AW-1:0];
                    r_bad <= (i_sym >= sam_pkg::SymW'(sam_pkg::Alphabet));
                    r_k <= '0;
                    r_status <= 1'b0;
                    if (i_go && i_op == sam_pkg::OP_CLEAR) begin
                        r_cnt <= (StW+1)'(1); r_last <= '0; r_mst <= '0; r_len <= '0;
                        r_best <= '0; r_bst <= '0; r_pos <= '0; r_dlast <= '0;
                    end
                end
                sam_pkg::S_CLR: r_clra <= r_clra + 1'b1;
                sam_pkg::S_CLR_ROOT: r_k <= r_k + 1'b1;
                sam_pkg::S_A_CHK: begin
                    r_status <= ~r_bad & o_stat.full;
                    r_p <= r_cnt[StW-1:0];
                    r_c <= LnkW'(r_last);
                end
                sam_pkg::S_A_NEWW: begin
                    r_k <= r_k + 1'b1;
                    if (last_k) begin
                        r_k <= '0; r_cnt <= r_cnt + 1'b1;
                        r_last <= r_p; r_dlast <= r_dlast + 1'b1;
                    end
                end
                sam_pkg::S_A_W1T: begin
                    if (r_trd != '0) begin
                        r_q <= r_trd; r_dc <= r_dpd;
                    end
                end
                sam_pkg::S_A_W1L: r_c <= r_lkd;
                sam_pkg::S_A_QDR: r_r <= r_cnt[StW-1:0];
                sam_pkg::S_A_CLN: r_cnt <= r_cnt + 1'b1;
                sam_pkg::S_A_CPW: r_k <= r_k + 1'b1;
                sam_pkg::S_A_W2T: ;
                sam_pkg::S_A_W2L: r_c <= r_lkd;
                sam_pkg::S_Q_T: r_c <= LnkW'(r_mst);
                sam_pkg::S_Q_TR: if (r_trd != '0) begin
                    r_mst <= r_trd; r_len <= nlen;
                end
                sam_pkg::S_Q_WL: begin
                    if (r_c == NoLink) begin
                        r_mst <= '0; r_len <= '0;
                    end
                end
                sam_pkg::S_Q_WT: ;
                sam_pkg::S_Q_WTR: begin
                    if (r_trd == '0) r_c <= r_lkd;
                    else r_mst <= r_trd;
                end
                sam_pkg::S_Q_DEPR: r_len <= r_dpd + 1'b1;
                sam_pkg::S_Q_UPD: begin
                    if (r_bad) begin
                        r_mst <= '0;
                    end
                    if (!r_bad && r_len > r_best) begin
                        r_best <= r_len;
                        r_bst <= r_pos + 1'b1 - sam_pkg::PosW'(r_len);
                    end
                    r_pos <= r_pos + 1'b1;
                end
                default: ;
            endcase
            if (i_cmd.st == sam_pkg::S_Q_T && r_bad) r_len <= '0;
        end
    end

    assign o_status = r_status;
    assign o_mlen   = r_len;
    assign o_blen   = r_best;
    assign o_bstart = r_bst;
endmodule
`default_nettype wire

[src/sam_checker.sv]
// port-level checks for the suffix automaton matcher
// depends on suffix_automaton_lcs_top ports
`default_nettype none
module sam_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_done,
    input wire        o_status,
    input wire [10:0] o_best_length,
    input wire [10:0] o_match_length
);
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("done while idle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("no busy after transfer");
    a_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_status |-> o_match_length <= o_best_length)
        else $error("match exceeds best");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than a cycle");
endmodule
bind suffix_automaton_lcs_top sam_checker u_chk (.*);
`default_nettype wire
